### rtl/emcd_pkg.sv
// Shared widths, constants and reciprocal multipliers for the epoch-to-civil converter.
package emcd_pkg;

	localparam int unsigned NUM_STAGES = 11;

	// Field widths
	localparam int unsigned MS_W     = 48;
	localparam int unsigned YEAR_W   = 14;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned MDAY_W   = 5;
	localparam int unsigned HOUR_W   = 5;
	localparam int unsigned MINUTE_W = 6;
	localparam int unsigned SECOND_W = 6;
	localparam int unsigned MSEC_W   = 10;

	// Internal widths
	localparam int unsigned DAYS_W = 22;  // whole days since the epoch
	localparam int unsigned MSD_W  = 27;  // milliseconds within the day
	localparam int unsigned ERA_W  = 5;
	localparam int unsigned DOE_W  = 18;
	localparam int unsigned YOE_W  = 9;
	localparam int unsigned DOY_W  = 9;
	localparam int unsigned MP_W   = 4;
	localparam int unsigned SOD_W  = 17;  // seconds of the day
	localparam int unsigned MOD_W  = 11;  // minutes of the day

	// Day split: 86400000 = 84375 * 2^10
	localparam int unsigned DAY_LO_W  = 10;
	localparam int unsigned EST_DROP  = 14;
	localparam int unsigned EST_K     = 26;
	localparam logic [16:0] DAY_ODD   = 17'd84375;
	localparam logic [23:0] DAY_RECIP =
		24'((64'd1 << (EST_DROP + EST_K)) / 64'(DAY_ODD));

	// Calendar constants
	localparam logic [19:0] DAY_SHIFT    = 20'd719468;
	localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
	localparam logic [10:0] DAYS_4Y      = 11'd1460;
	localparam logic [15:0] DAYS_100Y    = 16'd36524;
	localparam logic [17:0] DAYS_400Y_M1 = 18'd146096;
	localparam logic [8:0]  DAYS_PER_YR  = 9'd365;
	localparam logic [8:0]  ERA_YEARS    = 9'd400;
	localparam logic [7:0]  MP_DIV       = 8'd153;
	localparam logic [3:0]  MP_JAN       = 4'd10;
	localparam logic [13:0] YEAR_MAX     = 14'd9999;

	// Time constants
	localparam logic [9:0] MS_PER_SEC   = 10'd1000;
	localparam logic [5:0] SIXTY        = 6'd60;

	// Ceiling reciprocals, exact for every operand in range
	localparam int unsigned ERA_K  = 40;
	localparam int unsigned Y4_K   = 28;
	localparam int unsigned YR_K   = 26;
	localparam int unsigned MP_K   = 19;
	localparam int unsigned SEC_K  = 37;
	localparam int unsigned MINA_K = 23;
	localparam int unsigned MINB_K = 17;

	localparam logic [22:0] ERA_RECIP =
		23'(((64'd1 << ERA_K) + 64'(DAYS_PER_ERA) - 64'd1) / 64'(DAYS_PER_ERA));
	localparam logic [17:0] Y4_RECIP =
		18'(((64'd1 << Y4_K) + 64'(DAYS_4Y) - 64'd1) / 64'(DAYS_4Y));
	localparam logic [17:0] YR_RECIP =
		18'(((64'd1 << YR_K) + 64'(DAYS_PER_YR) - 64'd1) / 64'(DAYS_PER_YR));
	localparam logic [11:0] MP_RECIP =
		12'(((64'd1 << MP_K) + 64'(MP_DIV) - 64'd1) / 64'(MP_DIV));
	localparam logic [27:0] SEC_RECIP =
		28'(((64'd1 << SEC_K) + 64'(MS_PER_SEC) - 64'd1) / 64'(MS_PER_SEC));
	localparam logic [17:0] MINA_RECIP =
		18'(((64'd1 << MINA_K) + 64'(SIXTY) - 64'd1) / 64'(SIXTY));
	localparam logic [11:0] MINB_RECIP =
		12'(((64'd1 << MINB_K) + 64'(SIXTY) - 64'd1) / 64'(SIXTY));

	// Day of the March-based year on which month mp starts: (153*mp + 2) / 5
	function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
		logic [DOY_W-1:0] r;
		unique case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

### rtl/emcd_pipe_ctrl.sv
// Valid bits and per-stage enables for the converter pipeline, with bubble collapse.
module emcd_pipe_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                epoch_valid,
	output logic                                epoch_ready,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic [emcd_pkg::NUM_STAGES-1:0]     en
);

	localparam int unsigned NS = emcd_pkg::NUM_STAGES;

	logic [NS-1:0] v_q;
	logic [NS-1:0] low_mask;

	// A stage may load when some stage at or after it is empty, or the output drains.
	always_comb begin
		for (int k = 0; k < NS; k++) begin
			low_mask = NS'((64'd1 << k) - 64'd1);
			en[k] = result_ready || ((v_q | low_mask) != {NS{1'b1}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= epoch_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign epoch_ready  = en[0];
	assign result_valid = v_q[NS-1];

	a_ready_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q != {NS{1'b1}}) |-> epoch_ready)
		else $error("input stalled while the pipeline has an empty stage");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(epoch_valid && epoch_ready) |=> v_q[0])
		else $error("accepted beat did not enter the first stage");

endmodule

### rtl/emcd_day_split.sv
// Stages 1-3: split the millisecond count into whole days and milliseconds of the day.
module emcd_day_split (
	input  logic                                clk,
	input  logic [emcd_pkg::NUM_STAGES-1:0]     en,
	input  logic [emcd_pkg::MS_W-1:0]           epoch_milliseconds,
	output logic [emcd_pkg::DAYS_W-1:0]         days_s3,
	output logic [emcd_pkg::MSD_W-1:0]          msd_s3
);

	localparam int unsigned XW = emcd_pkg::MS_W - emcd_pkg::DAY_LO_W;  // 38
	localparam int unsigned TW = XW - emcd_pkg::EST_DROP;             // 24

	logic [XW-1:0]                   x_s1, x_s2;
	logic [emcd_pkg::DAY_LO_W-1:0]   lo_s1, lo_s2;
	logic [2*TW-1:0]                 est_prod, est_s1;
	logic [emcd_pkg::DAYS_W-1:0]     q0, q_s2;
	logic [XW:0]                     back_prod;
	logic [XW-1:0]                   back_s2;
	logic [XW-1:0]                   diff;
	logic [17:0]                     rem;
	logic                            fix;
	logic [16:0]                     rem_adj;

	// Quotient estimate from the top bits; low by at most one.
	assign est_prod = (2*TW)'(epoch_milliseconds[emcd_pkg::MS_W-1 -: TW]) *
		(2*TW)'(emcd_pkg::DAY_RECIP);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s1   <= epoch_milliseconds[emcd_pkg::MS_W-1:emcd_pkg::DAY_LO_W];
			lo_s1  <= epoch_milliseconds[emcd_pkg::DAY_LO_W-1:0];
			est_s1 <= est_prod;
		end
	end

	assign q0        = est_s1[emcd_pkg::EST_K +: emcd_pkg::DAYS_W];
	assign back_prod = (XW+1)'(q0) * (XW+1)'(emcd_pkg::DAY_ODD);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			x_s2    <= x_s1;
			lo_s2   <= lo_s1;
			q_s2    <= q0;
			back_s2 <= back_prod[XW-1:0];
		end
	end

	// Remainder lies below twice the divisor: one correction step.
	assign diff    = x_s2 - back_s2;
	assign rem     = diff[17:0];
	assign fix     = rem >= 18'(emcd_pkg::DAY_ODD);
	assign rem_adj = fix ? 17'(rem - 18'(emcd_pkg::DAY_ODD)) : rem[16:0];

	always_ff @(posedge clk) begin
		if (en[2]) begin
			days_s3 <= q_s2 + emcd_pkg::DAYS_W'(fix);
			msd_s3  <= {rem_adj, lo_s2};
		end
	end

endmodule

### rtl/emcd_civil_date.sv
// Stages 4-11: days since the epoch to year, month and day of month.
module emcd_civil_date (
	input  logic                                clk,
	input  logic [emcd_pkg::NUM_STAGES-1:0]     en,
	input  logic [emcd_pkg::DAYS_W-1:0]         days_s3,
	output logic [emcd_pkg::YEAR_W-1:0]         year_s11,
	output logic [emcd_pkg::MONTH_W-1:0]        month_s11,
	output logic [emcd_pkg::MDAY_W-1:0]         day_s11
);

	localparam int unsigned DW = emcd_pkg::DAYS_W;

	logic [DW-1:0]                 shifted, shifted_s4;
	logic [DW+22:0]                era_prod;
	logic [emcd_pkg::ERA_W-1:0]    era_s4, era_s5, era_s6, era_s7, era_s8, era_s9, era_s10;
	logic [DW-1:0]                 doe_full;
	logic [emcd_pkg::DOE_W-1:0]    doe_s5, doe_s6, doe_s7, doe_s8;
	logic [35:0]                   a_prod;
	logic [6:0]                    a_s6;
	logic [2:0]                    b_s6;
	logic                          c_s6;
	logic [emcd_pkg::DOE_W-1:0]    t_s7;
	logic [35:0]                   y_prod;
	logic [emcd_pkg::YOE_W-1:0]    yoe_s8, yoe_s9, yoe_s10;
	logic [1:0]                    cent;
	logic [17:0]                   yr_base;
	logic [emcd_pkg::DOE_W-1:0]    doy_full;
	logic [emcd_pkg::DOY_W-1:0]    doy_s9, doy_s10;
	logic [10:0]                   mp_num;
	logic [22:0]                   mp_prod;
	logic [emcd_pkg::MP_W-1:0]     mp_s10;
	logic [emcd_pkg::DOY_W-1:0]    mday;
	logic [emcd_pkg::YEAR_W-1:0]   year_raw;
	logic [emcd_pkg::MONTH_W-1:0]  month;

	// Stage 4: rebase to 0000-03-01 and find the 400-year era
	assign shifted  = days_s3 + DW'(emcd_pkg::DAY_SHIFT);
	assign era_prod = (DW+23)'(shifted) * (DW+23)'(emcd_pkg::ERA_RECIP);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			shifted_s4 <= shifted;
			era_s4     <= era_prod[emcd_pkg::ERA_K +: emcd_pkg::ERA_W];
		end
	end

	// Stage 5: day of era
	assign doe_full = shifted_s4 - DW'(DW'(era_s4) * DW'(emcd_pkg::DAYS_PER_ERA));

	always_ff @(posedge clk) begin
		if (en[4]) begin
			era_s5 <= era_s4;
			doe_s5 <= doe_full[emcd_pkg::DOE_W-1:0];
		end
	end

	// Stage 6: leap corrections doe/1460, doe/36524, doe/146096
	assign a_prod = 36'(doe_s5) * 36'(emcd_pkg::Y4_RECIP);

	always_ff @(posedge clk) begin
		if (en[5]) begin
			era_s6 <= era_s5;
			doe_s6 <= doe_s5;
			a_s6   <= a_prod[emcd_pkg::Y4_K +: 7];
			b_s6   <= 3'(doe_s5 >= 18'(emcd_pkg::DAYS_100Y))
				+ 3'(doe_s5 >= 18'(2 * emcd_pkg::DAYS_100Y))
				+ 3'(doe_s5 >= 18'(3 * emcd_pkg::DAYS_100Y))
				+ 3'(doe_s5 >= emcd_pkg::DAYS_400Y_M1);
			c_s6   <= doe_s5 == emcd_pkg::DAYS_400Y_M1;
		end
	end

	// Stage 7: fold corrections
	always_ff @(posedge clk) begin
		if (en[6]) begin
			era_s7 <= era_s6;
			doe_s7 <= doe_s6;
			t_s7   <= doe_s6 - 18'(a_s6) + 18'(b_s6) - 18'(c_s6);
		end
	end

	// Stage 8: year of era
	assign y_prod = 36'(t_s7) * 36'(emcd_pkg::YR_RECIP);

	always_ff @(posedge clk) begin
		if (en[7]) begin
			era_s8 <= era_s7;
			doe_s8 <= doe_s7;
			yoe_s8 <= y_prod[emcd_pkg::YR_K +: emcd_pkg::YOE_W];
		end
	end

	// Stage 9: day of the March-based year
	assign cent = 2'(yoe_s8 >= 9'd100) + 2'(yoe_s8 >= 9'd200) + 2'(yoe_s8 >= 9'd300);
	assign yr_base = 18'(18'(yoe_s8) * 18'(emcd_pkg::DAYS_PER_YR))
		+ 18'(yoe_s8[emcd_pkg::YOE_W-1:2]) - 18'(cent);
	assign doy_full = doe_s8 - yr_base;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			era_s9 <= era_s8;
			yoe_s9 <= yoe_s8;
			doy_s9 <= doy_full[emcd_pkg::DOY_W-1:0];
		end
	end

	// Stage 10: March-based month
	assign mp_num  = 11'(11'(doy_s9) * 11'd5) + 11'd2;
	assign mp_prod = 23'(mp_num) * 23'(emcd_pkg::MP_RECIP);

	always_ff @(posedge clk) begin
		if (en[9]) begin
			era_s10 <= era_s9;
			yoe_s10 <= yoe_s9;
			doy_s10 <= doy_s9;
			mp_s10  <= mp_prod[emcd_pkg::MP_K +: emcd_pkg::MP_W];
		end
	end

	// Stage 11: rotate to January base, assemble and saturate the year
	assign mday  = emcd_pkg::month_start(mp_s10);
	assign month = (mp_s10 < emcd_pkg::MP_JAN) ? (mp_s10 + 4'd2) : (mp_s10 - emcd_pkg::MP_JAN);
	assign year_raw = emcd_pkg::YEAR_W'(yoe_s10)
		+ emcd_pkg::YEAR_W'(emcd_pkg::YEAR_W'(era_s10) * emcd_pkg::YEAR_W'(emcd_pkg::ERA_YEARS))
		+ emcd_pkg::YEAR_W'(mp_s10 >= emcd_pkg::MP_JAN);

	always_ff @(posedge clk) begin
		if (en[10]) begin
			year_s11  <= (year_raw > emcd_pkg::YEAR_MAX) ? emcd_pkg::YEAR_MAX : year_raw;
			month_s11 <= month;
			day_s11   <= emcd_pkg::MDAY_W'(doy_s10 - mday);
		end
	end

endmodule

### rtl/emcd_time_of_day.sv
// Stages 4-11: milliseconds of the day to hour, minute, second and millisecond.
module emcd_time_of_day (
	input  logic                                clk,
	input  logic [emcd_pkg::NUM_STAGES-1:0]     en,
	input  logic [emcd_pkg::MSD_W-1:0]          msd_s3,
	output logic [emcd_pkg::HOUR_W-1:0]         hour_s11,
	output logic [emcd_pkg::MINUTE_W-1:0]       minute_s11,
	output logic [emcd_pkg::SECOND_W-1:0]       second_s11,
	output logic [emcd_pkg::MSEC_W-1:0]         msec_s11
);

	localparam int unsigned MW = emcd_pkg::MSD_W;

	logic [MW+27:0]                  sec_prod;
	logic [MW-1:0]                   msd_s4, msec_full;
	logic [emcd_pkg::SOD_W-1:0]      sod_s4, sod_s5, sod_s6;
	logic [emcd_pkg::MSEC_W-1:0]     msec_s5, msec_s6, msec_s7, msec_s8, msec_s9, msec_s10;
	logic [34:0]                     mina_prod;
	logic [emcd_pkg::MOD_W-1:0]      mod_s6, mod_s7, mod_s8;
	logic [emcd_pkg::SOD_W-1:0]      sec_full;
	logic [emcd_pkg::SECOND_W-1:0]   sec_s7, sec_s8, sec_s9, sec_s10;
	logic [22:0]                     minb_prod;
	logic [emcd_pkg::HOUR_W-1:0]     hour_s8, hour_s9, hour_s10;
	logic [emcd_pkg::MOD_W-1:0]      min_full;
	logic [emcd_pkg::MINUTE_W-1:0]   min_s9, min_s10;

	// Stage 4: seconds of the day
	assign sec_prod = (MW+28)'(msd_s3) * (MW+28)'(emcd_pkg::SEC_RECIP);

	always_ff @(posedge clk) begin
		if (en[3]) begin
			msd_s4 <= msd_s3;
			sod_s4 <= sec_prod[emcd_pkg::SEC_K +: emcd_pkg::SOD_W];
		end
	end

	// Stage 5: millisecond of the second
	assign msec_full = msd_s4 - MW'(MW'(sod_s4) * MW'(emcd_pkg::MS_PER_SEC));

	always_ff @(posedge clk) begin
		if (en[4]) begin
			sod_s5  <= sod_s4;
			msec_s5 <= msec_full[emcd_pkg::MSEC_W-1:0];
		end
	end

	// Stage 6: minutes of the day
	assign mina_prod = 35'(sod_s5) * 35'(emcd_pkg::MINA_RECIP);

	always_ff @(posedge clk) begin
		if (en[5]) begin
			sod_s6  <= sod_s5;
			msec_s6 <= msec_s5;
			mod_s6  <= mina_prod[emcd_pkg::MINA_K +: emcd_pkg::MOD_W];
		end
	end

	// Stage 7: second of the minute
	assign sec_full = sod_s6 - emcd_pkg::SOD_W'(emcd_pkg::SOD_W'(mod_s6) *
		emcd_pkg::SOD_W'(emcd_pkg::SIXTY));

	always_ff @(posedge clk) begin
		if (en[6]) begin
			mod_s7  <= mod_s6;
			msec_s7 <= msec_s6;
			sec_s7  <= sec_full[emcd_pkg::SECOND_W-1:0];
		end
	end

	// Stage 8: hour
	assign minb_prod = 23'(mod_s7) * 23'(emcd_pkg::MINB_RECIP);

	always_ff @(posedge clk) begin
		if (en[7]) begin
			mod_s8  <= mod_s7;
			msec_s8 <= msec_s7;
			sec_s8  <= sec_s7;
			hour_s8 <= minb_prod[emcd_pkg::MINB_K +: emcd_pkg::HOUR_W];
		end
	end

	// Stage 9: minute of the hour
	assign min_full = mod_s8 - emcd_pkg::MOD_W'(emcd_pkg::MOD_W'(hour_s8) *
		emcd_pkg::MOD_W'(emcd_pkg::SIXTY));

	always_ff @(posedge clk) begin
		if (en[8]) begin
			msec_s9 <= msec_s8;
			sec_s9  <= sec_s8;
			hour_s9 <= hour_s8;
			min_s9  <= min_full[emcd_pkg::MINUTE_W-1:0];
		end
	end

	// Stages 10-11: hold alignment with the date path
	always_ff @(posedge clk) begin
		if (en[9]) begin
			msec_s10 <= msec_s9;
			sec_s10  <= sec_s9;
			hour_s10 <= hour_s9;
			min_s10  <= min_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en[10]) begin
			msec_s11   <= msec_s10;
			second_s11 <= sec_s10;
			hour_s11   <= hour_s10;
			minute_s11 <= min_s10;
		end
	end

endmodule

### rtl/epoch_ms_to_civil_datetime_core.sv
// Epoch milliseconds to civil date and time of day: eleven-stage pipeline top level.
// An accepted beat enters stage 1; the stage-11 registers drive the result ports.
// Throughput: one beat per clock while result_ready is high or some stage is empty.
// A stalled output holds; upstream stages keep filling any empty stage behind it.
// Reset (arst_n low, asynchronous) clears all stage valid bits; data registers
// are not reset.
module epoch_ms_to_civil_datetime_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                epoch_valid,
	output logic                                epoch_ready,
	input  logic [emcd_pkg::MS_W-1:0]           epoch_milliseconds,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic [emcd_pkg::YEAR_W-1:0]         year,
	output logic [emcd_pkg::MONTH_W-1:0]        month_index,
	output logic [emcd_pkg::MDAY_W-1:0]         day_index,
	output logic [emcd_pkg::HOUR_W-1:0]         hour,
	output logic [emcd_pkg::MINUTE_W-1:0]       minute,
	output logic [emcd_pkg::SECOND_W-1:0]       second,
	output logic [emcd_pkg::MSEC_W-1:0]         millisecond
);

	logic [emcd_pkg::NUM_STAGES-1:0] en;
	logic [emcd_pkg::DAYS_W-1:0]     days_s3;
	logic [emcd_pkg::MSD_W-1:0]      msd_s3;

	emcd_pipe_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.epoch_valid  (epoch_valid),
		.epoch_ready  (epoch_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.en           (en)
	);

	emcd_day_split u_split (
		.clk                (clk),
		.en                 (en),
		.epoch_milliseconds (epoch_milliseconds),
		.days_s3            (days_s3),
		.msd_s3             (msd_s3)
	);

	emcd_civil_date u_date (
		.clk       (clk),
		.en        (en),
		.days_s3   (days_s3),
		.year_s11  (year),
		.month_s11 (month_index),
		.day_s11   (day_index)
	);

	emcd_time_of_day u_time (
		.clk        (clk),
		.en         (en),
		.msd_s3     (msd_s3),
		.hour_s11   (hour),
		.minute_s11 (minute),
		.second_s11 (second),
		.msec_s11   (millisecond)
	);

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (year <= emcd_pkg::YEAR_MAX) && (month_index <= 4'd11)
			&& (day_index <= 5'd30))
		else $error("date field out of range");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59)
			&& (millisecond <= 10'd999))
		else $error("time field out of range");

endmodule

### tb/tb_epoch_ms_to_civil_datetime_core.sv
// Testbench for the epoch-milliseconds to civil date and time-of-day pipeline.
`timescale 1ns / 100ps

module tb_epoch_ms_to_civil_datetime_core;

	localparam longint unsigned MS_PER_DAY   = 64'd86400000;
	localparam longint unsigned MS_PER_HOUR  = 64'd3600000;
	localparam longint unsigned MS_PER_MIN   = 64'd60000;
	localparam longint unsigned MS_PER_SEC_L = 64'd1000;
	localparam longint unsigned EPOCH_OFFSET = 64'd719468;  // 0000-03-01 to 1970-01-01
	localparam longint unsigned ERA_DAYS     = 64'd146097;
	localparam longint unsigned YEAR_CAP     = 64'd9999;
	localparam longint unsigned STAMP_MAX    = 64'hFFFF_FFFF_FFFF;
	localparam int              LONG_HOLD    = 300;
	localparam int              STALL_LIMIT  = 5000;

	typedef struct packed {
		logic [emcd_pkg::YEAR_W-1:0]   year;
		logic [emcd_pkg::MONTH_W-1:0]  month;
		logic [emcd_pkg::MDAY_W-1:0]   mday;
		logic [emcd_pkg::HOUR_W-1:0]   hour;
		logic [emcd_pkg::MINUTE_W-1:0] minute;
		logic [emcd_pkg::SECOND_W-1:0] sec;
		logic [emcd_pkg::MSEC_W-1:0]   msec;
	} civil_t;

	logic                          clk                = 1'b0;
	logic                          arst_n             = 1'b0;
	logic                          epoch_valid        = 1'b0;
	logic                          epoch_ready;
	logic [emcd_pkg::MS_W-1:0]     epoch_milliseconds = '0;
	logic                          result_valid;
	logic                          result_ready       = 1'b0;
	logic [emcd_pkg::YEAR_W-1:0]   year;
	logic [emcd_pkg::MONTH_W-1:0]  month_index;
	logic [emcd_pkg::MDAY_W-1:0]   day_index;
	logic [emcd_pkg::HOUR_W-1:0]   hour;
	logic [emcd_pkg::MINUTE_W-1:0] minute;
	logic [emcd_pkg::SECOND_W-1:0] second;
	logic [emcd_pkg::MSEC_W-1:0]   millisecond;

	logic [emcd_pkg::MS_W-1:0] ms_backlog[$];
	civil_t          civil_due[$];
	logic            in_fire       = 1'b0;
	int              send_idle_pct = 0;
	int              recv_idle_pct = 0;
	int              hold_req      = 0;
	int              hold_ack      = 0;
	int              hold_left     = 0;
	int              stall_cycles  = 0;
	int              fail_count    = 0;

	epoch_ms_to_civil_datetime_core dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.epoch_valid        (epoch_valid),
		.epoch_ready        (epoch_ready),
		.epoch_milliseconds (epoch_milliseconds),
		.result_valid       (result_valid),
		.result_ready       (result_ready),
		.year               (year),
		.month_index        (month_index),
		.day_index          (day_index),
		.hour               (hour),
		.minute             (minute),
		.second             (second),
		.millisecond        (millisecond)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Split a timestamp into days and time of day, then resolve the day count
	// through 400-year eras starting on March 1.
	function automatic civil_t civil_of(input logic [emcd_pkg::MS_W-1:0] stamp);
		longint unsigned day_num, ms_of_day, shifted, era_idx, day_of_era;
		longint unsigned year_of_era, day_of_year, march_month, year_full;
		civil_t c;
		day_num     = stamp / MS_PER_DAY;
		ms_of_day   = stamp % MS_PER_DAY;
		shifted     = day_num + EPOCH_OFFSET;
		era_idx     = shifted / ERA_DAYS;
		day_of_era  = shifted % ERA_DAYS;
		year_of_era = (day_of_era - day_of_era / 1460 + day_of_era / 36524
			- day_of_era / 146096) / 365;
		day_of_year = day_of_era - (365 * year_of_era + year_of_era / 4 - year_of_era / 100);
		march_month = (5 * day_of_year + 2) / 153;
		year_full   = year_of_era + era_idx * 400 + ((march_month >= 10) ? 1 : 0);
		c.year   = emcd_pkg::YEAR_W'((year_full > YEAR_CAP) ? YEAR_CAP : year_full);
		c.month  = emcd_pkg::MONTH_W'((march_month < 10) ? march_month + 2
			: march_month - 10);
		c.mday   = emcd_pkg::MDAY_W'(day_of_year - (153 * march_month + 2) / 5);
		c.hour   = emcd_pkg::HOUR_W'(ms_of_day / MS_PER_HOUR);
		c.minute = emcd_pkg::MINUTE_W'((ms_of_day / MS_PER_MIN) % 60);
		c.sec    = emcd_pkg::SECOND_W'((ms_of_day / MS_PER_SEC_L) % 60);
		c.msec   = emcd_pkg::MSEC_W'(ms_of_day % MS_PER_SEC_L);
		return c;
	endfunction

	// Days since 1970-01-01 for a date on or after it (month and day one-based).
	function automatic longint days_since_epoch(input int y, input int m, input int d);
		longint yy, era_idx, yoe, doy, doe;
		yy      = longint'((m <= 2) ? y - 1 : y);
		era_idx = yy / 400;
		yoe     = yy - era_idx * 400;
		doy     = longint'((153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1);
		doe     = yoe * 365 + yoe / 4 - yoe / 100 + doy;
		return era_idx * 146097 + doe - 719468;
	endfunction

	function automatic logic [emcd_pkg::MS_W-1:0] stamp_of(input int y, input int m,
			input int d, input longint tod);
		longint unsigned s;
		s = longint'(days_since_epoch(y, m, d)) * MS_PER_DAY + tod;
		if (s > STAMP_MAX)
			s = STAMP_MAX - $urandom_range(0, 99999);
		return emcd_pkg::MS_W'(s);
	endfunction

	function automatic logic [emcd_pkg::MS_W-1:0] random_stamp();
		int              kind, y, m;
		longint          day_num, tod;
		longint unsigned s;
		kind = $urandom_range(0, 9);
		if (kind <= 3) begin
			s = {$urandom, $urandom};
			s = s & STAMP_MAX;
		end else if (kind <= 7) begin
			y = $urandom_range(1970, 10889);
			m = $urandom_range(1, 12);
			case ($urandom_range(0, 2))
				0: day_num = days_since_epoch(y, m, 1);
				1: day_num = days_since_epoch((m == 12) ? y + 1 : y,
					(m == 12) ? 1 : m + 1, 1) - 1;
				default: day_num = days_since_epoch(y, m, $urandom_range(1, 28));
			endcase
			case ($urandom_range(0, 3))
				0: tod = 0;
				1: tod = MS_PER_DAY - 1;
				2: tod = longint'($urandom_range(0, 1439)) * MS_PER_MIN
					+ (($urandom_range(0, 1) != 0) ? MS_PER_MIN - 1 : 0);
				default: tod = longint'($urandom_range(0, 32'(MS_PER_DAY - 1)));
			endcase
			s = longint'(day_num) * MS_PER_DAY + tod;
			if (s > STAMP_MAX)
				s = STAMP_MAX - $urandom_range(0, 99999);
		end else if (kind == 8) begin
			s = longint'($urandom_range(0, 200000000));
		end else begin
			s = STAMP_MAX - $urandom;
		end
		return emcd_pkg::MS_W'(s);
	endfunction

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	// Present the next queued timestamp once the current beat is taken.
	always @(negedge clk) begin
		if (!arst_n)
			epoch_valid <= 1'b0;
		else if (!epoch_valid || in_fire) begin
			if (ms_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				epoch_milliseconds <= ms_backlog.pop_front();
				epoch_valid        <= 1'b1;
			end else
				epoch_valid <= 1'b0;
		end
	end

	// Result side: random back-pressure plus an occasional long hold-off.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			result_ready <= 1'b0;
			hold_left    <= hold_left - 1;
		end else if (hold_req != hold_ack) begin
			result_ready <= 1'b0;
			hold_left    <= LONG_HOLD;
			hold_ack     <= hold_req;
		end else
			result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	always @(posedge clk) begin : monitor
		civil_t want;
		logic   in_beat, out_beat;
		in_beat  = arst_n && epoch_valid && epoch_ready;
		out_beat = arst_n && result_valid && result_ready;
		in_fire <= in_beat;
		if (in_beat)
			civil_due.push_back(civil_of(epoch_milliseconds));
		if (out_beat) begin
			if (civil_due.size() == 0) begin
				$display("%0t: result beat with nothing expected", $time);
				fail_count++;
			end else begin
				want = civil_due.pop_front();
				check_field("year", 64'(want.year), 64'(year));
				check_field("month_index", 64'(want.month), 64'(month_index));
				check_field("day_index", 64'(want.mday), 64'(day_index));
				check_field("hour", 64'(want.hour), 64'(hour));
				check_field("minute", 64'(want.minute), 64'(minute));
				check_field("second", 64'(want.sec), 64'(second));
				check_field("millisecond", 64'(want.msec), 64'(millisecond));
			end
		end
		// Watchdog: abort when neither side moves for too long.
		if (in_beat || out_beat)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Hold the sender until every expected result has come back.
	task automatic drain();
		while (ms_backlog.size() != 0 || epoch_valid || civil_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_random(input int count, input int s_pct, input int r_pct,
			input bit long_hold);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int i = 0; i < count; i++)
			ms_backlog.push_back(random_stamp());
		if (long_hold)
			hold_req++;
		drain();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 27;
		recv_idle_pct = 81;
		ms_backlog.push_back(48'd0);
		ms_backlog.push_back(48'd1);
		ms_backlog.push_back(48'd999);
		ms_backlog.push_back(48'd59999);
		ms_backlog.push_back(48'd3599999);
		ms_backlog.push_back(48'd86399999);
		ms_backlog.push_back(48'd86400000);
		ms_backlog.push_back(stamp_of(1972, 2, 29, 43200000));
		ms_backlog.push_back(stamp_of(1972, 12, 31, MS_PER_DAY - 1));
		ms_backlog.push_back(stamp_of(1999, 12, 31, MS_PER_DAY - 1));
		// last day of an era, then the first day of the next one
		ms_backlog.push_back(stamp_of(2000, 2, 29, MS_PER_DAY - 1));
		ms_backlog.push_back(stamp_of(2000, 3, 1, 0));
		ms_backlog.push_back(stamp_of(2022, 12, 31, MS_PER_DAY - 1));
		ms_backlog.push_back(stamp_of(2023, 1, 1, 0));
		ms_backlog.push_back(stamp_of(2100, 2, 28, MS_PER_DAY - 1));
		ms_backlog.push_back(stamp_of(2100, 3, 1, 0));
		ms_backlog.push_back(stamp_of(2400, 2, 29, 45296789));
		// year saturation boundary
		ms_backlog.push_back(stamp_of(9999, 12, 31, MS_PER_DAY - 1));
		ms_backlog.push_back(stamp_of(10000, 1, 1, 0));
		ms_backlog.push_back(48'hFFFF_FFFF_FFFF);
		ms_backlog.push_back(48'h8000_0000_0000);
		ms_backlog.push_back(48'h5555_5555_5555);
		ms_backlog.push_back(48'hAAAA_AAAA_AAAA);
		drain();

		run_random(510, 27, 81, 1'b0);
		run_random(510, 81, 27, 1'b0);
		run_random(510, 0, 0, 1'b1);

		repeat (3 * emcd_pkg::NUM_STAGES) @(negedge clk);
		if (civil_due.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, civil_due.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### epoch_ms_to_civil_datetime_core.f
rtl/emcd_pkg.sv
rtl/emcd_pipe_ctrl.sv
rtl/emcd_day_split.sv
rtl/emcd_civil_date.sv
rtl/emcd_time_of_day.sv
rtl/epoch_ms_to_civil_datetime_core.sv
tb/tb_epoch_ms_to_civil_datetime_core.sv
